// ===== sv/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types, field widths and the microcode program of the jump search
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

  localparam int IdxW   = 10;  // entry_index and position
  localparam int CountW = 11;  // entry_count register
  localparam int DataW  = 32;  // table entries and keys
  localparam int StepW  = 12;  // block bounds may run past the count
  localparam int RootW  = 6;   // floor(sqrt(2047)) = 45
  localparam int UpcW   = 5;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [UpcW-1:0] upc_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DISPATCH,
    OP_SQ_INC,
    OP_JUMP_INIT,
    OP_RD_END,
    OP_ADVANCE,
    OP_RD_PREV,
    OP_PREV_INC,
    OP_SET_MISS,
    OP_SET_HIT,
    OP_EMIT
  } op_e;

  // Branch conditions.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_SEARCH,
    COND_N_ZERO,
    COND_SQ_LE_N,
    COND_DATA_GE_KEY,
    COND_STEP_LT_N,
    COND_NEXT_NE_END,
    COND_DATA_EQ_KEY,
    COND_OUT_FULL
  } cond_e;

  // When the operation of a control word takes effect.
  typedef enum logic [1:0] {
    EX_ALWAYS,
    EX_TAKEN,
    EX_NOT_TAKEN
  } exec_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    exec_e exec;
    upc_t  target;
  } uword_t;

  // Program addresses.
  localparam upc_t PC_DISPATCH = 5'd0;
  localparam upc_t PC_EMPTY    = 5'd1;
  localparam upc_t PC_SQRT     = 5'd2;
  localparam upc_t PC_JINIT    = 5'd3;
  localparam upc_t PC_JREAD    = 5'd4;
  localparam upc_t PC_JTEST    = 5'd5;
  localparam upc_t PC_JNEXT    = 5'd6;
  localparam upc_t PC_MISS     = 5'd7;
  localparam upc_t PC_SCAN     = 5'd8;
  localparam upc_t PC_STEST    = 5'd9;
  localparam upc_t PC_SNEXT    = 5'd10;
  localparam upc_t PC_SOUT     = 5'd11;
  localparam upc_t PC_CHECK    = 5'd12;
  localparam upc_t PC_NOMATCH  = 5'd13;
  localparam upc_t PC_HIT      = 5'd14;
  localparam upc_t PC_EMIT     = 5'd15;
  localparam upc_t PC_DONE     = 5'd16;

  // Control store. A taken branch goes to target, otherwise to the next step.
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '{OP_NONE, COND_ALWAYS, EX_ALWAYS, PC_DISPATCH};
    unique case (pc)
      PC_DISPATCH: w = '{OP_DISPATCH, COND_NOT_SEARCH,  EX_ALWAYS,    PC_DISPATCH};
      PC_EMPTY:    w = '{OP_NONE,     COND_N_ZERO,      EX_ALWAYS,    PC_MISS};
      PC_SQRT:     w = '{OP_SQ_INC,   COND_SQ_LE_N,     EX_TAKEN,     PC_SQRT};
      PC_JINIT:    w = '{OP_JUMP_INIT, COND_NEVER,      EX_ALWAYS,    PC_DISPATCH};
      PC_JREAD:    w = '{OP_RD_END,   COND_NEVER,       EX_ALWAYS,    PC_DISPATCH};
      PC_JTEST:    w = '{OP_NONE,     COND_DATA_GE_KEY, EX_ALWAYS,    PC_SCAN};
      PC_JNEXT:    w = '{OP_ADVANCE,  COND_STEP_LT_N,   EX_ALWAYS,    PC_JREAD};
      PC_MISS:     w = '{OP_SET_MISS, COND_ALWAYS,      EX_ALWAYS,    PC_EMIT};
      PC_SCAN:     w = '{OP_RD_PREV,  COND_NEVER,       EX_ALWAYS,    PC_DISPATCH};
      PC_STEST:    w = '{OP_NONE,     COND_DATA_GE_KEY, EX_ALWAYS,    PC_CHECK};
      PC_SNEXT:    w = '{OP_PREV_INC, COND_NEXT_NE_END, EX_ALWAYS,    PC_SCAN};
      PC_SOUT:     w = '{OP_NONE,     COND_ALWAYS,      EX_ALWAYS,    PC_MISS};
      PC_CHECK:    w = '{OP_NONE,     COND_DATA_EQ_KEY, EX_ALWAYS,    PC_HIT};
      PC_NOMATCH:  w = '{OP_NONE,     COND_ALWAYS,      EX_ALWAYS,    PC_MISS};
      PC_HIT:      w = '{OP_SET_HIT,  COND_NEVER,       EX_ALWAYS,    PC_DISPATCH};
      PC_EMIT:     w = '{OP_EMIT,     COND_OUT_FULL,    EX_NOT_TAKEN, PC_EMIT};
      PC_DONE:     w = '{OP_NONE,     COND_ALWAYS,      EX_ALWAYS,    PC_DISPATCH};
      default:     w = '{OP_NONE,     COND_ALWAYS,      EX_ALWAYS,    PC_DISPATCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/jss_in_if.sv =====
// ----------------------------------------------------------------------------
// jss_in_if
// Command channel: table writes and search requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_in_if;
  import jss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IdxW-1:0]         entry_index;
  logic signed [DataW-1:0] entry_value;
  logic signed [DataW-1:0] search_key;

  modport source (
    output valid, command, entry_index, entry_value, search_key,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, entry_value, search_key,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/jss_out_if.sv =====
// ----------------------------------------------------------------------------
// jss_out_if
// Result channel: one beat per search.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_out_if;
  import jss_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [IdxW-1:0] position;

  modport source (
    output valid, found, position,
    input  ready
  );

  modport sink (
    input  valid, found, position,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/jss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// jss_cfg_if
// Configuration write channel for the entry count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_cfg_if;
  import jss_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] entry_count;

  modport source (
    output valid, entry_count,
    input  ready
  );

  modport sink (
    input  valid, entry_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/jump_search_sorted_table.sv =====
// ----------------------------------------------------------------------------
// jump_search_sorted_table
// Sorted table of signed 32-bit entries with a microcoded jump search.
// ----------------------------------------------------------------------------
// A write beat stores one table entry and returns nothing.
// A search beat returns one result beat. The search first finds
// floor(sqrt(n)) by stepping through squares, then probes the last entry
// of each block and finally scans one block; each probe takes a read step,
// a test step and an advance step because the table RAM has one read port
// with registered data. The next beat is taken once the result sits in the
// output register, even while that result still waits to be taken.
`default_nettype none

module jump_search_sorted_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jss_in_if.sink    in_i,
  jss_out_if.source out_o,
  jss_cfg_if.sink   cfg_i
);
  import jss_pkg::*;

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Sequencer and control registers.
  upc_t              pc_q, pc_d;
  logic [CountW-1:0] count_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [IdxW-1:0]   out_pos_q;

  // Datapath registers.
  logic signed [DataW-1:0] key_q;
  logic [CountW-1:0]       n_q;
  logic [RootW-1:0]        s_q;
  logic [StepW-1:0]        sq_q;
  logic [StepW-1:0]        step_q;
  logic [StepW-1:0]        prev_q;
  logic                    hit_q;
  logic [IdxW-1:0]         res_pos_q;

  uword_t            uw;
  logic              taken;
  logic              exec;
  logic              in_fire;
  logic              search_go;
  logic [CountW-1:0] n_cap;
  logic [StepW-1:0]  n_ext;
  logic [StepW-1:0]  end_w;
  logic              ram_we;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [DataW-1:0]  ram_rdata;

  assign uw        = ucode(pc_q);
  assign in_i.ready = (uw.op == OP_DISPATCH);
  assign cfg_i.ready = 1'b1;
  assign in_fire   = in_i.valid & in_i.ready;
  assign search_go = in_fire & (in_i.command == CMD_SEARCH);

  assign n_cap = (int'(count_q) > TABLE_DEPTH) ? CountW'(TABLE_DEPTH) : count_q;
  assign n_ext = StepW'(n_q);
  assign end_w = (step_q < n_ext) ? step_q : n_ext;

  always_comb begin
    case (uw.cond)
      COND_NEVER:       taken = 1'b0;
      COND_ALWAYS:      taken = 1'b1;
      COND_NOT_SEARCH:  taken = !search_go;
      COND_N_ZERO:      taken = (n_q == '0);
      COND_SQ_LE_N:     taken = (sq_q <= n_ext);
      COND_DATA_GE_KEY: taken = ($signed(ram_rdata) >= key_q);
      COND_STEP_LT_N:   taken = (step_q < n_ext);
      COND_NEXT_NE_END: taken = ((prev_q + StepW'(1)) != end_w);
      COND_DATA_EQ_KEY: taken = ($signed(ram_rdata) == key_q);
      COND_OUT_FULL:    taken = out_valid_q & !out_o.ready;
      default:          taken = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.exec)
      EX_ALWAYS:    exec = 1'b1;
      EX_TAKEN:     exec = taken;
      EX_NOT_TAKEN: exec = !taken;
      default:      exec = 1'b0;
    endcase
  end

  assign pc_d = taken ? uw.target : pc_q + upc_t'(1);

  // Table RAM.
  assign ram_we = in_fire & (in_i.command == CMD_WRITE)
                & (int'(in_i.entry_index) < TABLE_DEPTH);
  assign ram_re = (uw.op == OP_RD_END) | (uw.op == OP_RD_PREV);
  assign ram_raddr = (uw.op == OP_RD_END) ? AddrW'(end_w - StepW'(1)) : AddrW'(prev_q);

  jss_ram #(
    .Width(DataW),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(in_i.entry_index)),
    .wdata_i(in_i.entry_value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_DISPATCH;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_pos_q   <= '0;
    end else begin
      pc_q <= pc_d;
      if (cfg_i.valid) begin
        count_q <= cfg_i.entry_count;
      end
      if (uw.op == OP_EMIT && exec) begin
        out_valid_q <= 1'b1;
        out_found_q <= hit_q;
        out_pos_q   <= res_pos_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      case (uw.op)
        OP_DISPATCH: begin
          if (search_go) begin
            key_q <= in_i.search_key;
            n_q   <= n_cap;
            s_q   <= RootW'(1);
            sq_q  <= StepW'(4);
          end
        end
        OP_SQ_INC: begin
          // (s + 2)^2 = (s + 1)^2 + 2s + 3
          s_q  <= s_q + RootW'(1);
          sq_q <= sq_q + StepW'({s_q, 1'b0}) + StepW'(3);
        end
        OP_JUMP_INIT: begin
          step_q <= StepW'(s_q);
          prev_q <= '0;
        end
        OP_ADVANCE: begin
          prev_q <= step_q;
          step_q <= step_q + StepW'(s_q);
        end
        OP_PREV_INC: begin
          prev_q <= prev_q + StepW'(1);
        end
        OP_SET_MISS: begin
          hit_q     <= 1'b0;
          res_pos_q <= '0;
        end
        OP_SET_HIT: begin
          hit_q     <= 1'b1;
          res_pos_q <= IdxW'(prev_q);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_pos_q;

  // The linear scan never runs past the end of its block.
  a_scan_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_SCAN) |-> (prev_q < end_w))
    else $error("scan index left its block");

  // The root found is the largest s with s*s <= n.
  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_JINIT) |-> (sq_q > n_ext) && (s_q != '0))
    else $error("step size is not floor(sqrt(n))");

  // A new result beat appears only after the emit step.
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(pc_q) == PC_EMIT))
    else $error("result beat raised outside the emit step");

  // The table is written only while the sequencer waits for a command.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (pc_q == PC_DISPATCH))
    else $error("table written during a search");

endmodule

`default_nettype wire

// ===== sv/jss_ram.sv =====
// ----------------------------------------------------------------------------
// jss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
